[hw/rtl/md_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package md_pkg;

   localparam int unsigned DATA_WIDTH = 32;
   localparam int unsigned CNT_WIDTH  = $clog2(DATA_WIDTH);

   localparam logic [DATA_WIDTH-1:0] MODULUS_RESET = DATA_WIDTH'(64'd1000000007);

   typedef struct packed {
      logic [DATA_WIDTH-1:0] dividend;
      logic [DATA_WIDTH-1:0] divisor;
   } req_type;

   typedef struct packed {
      logic [DATA_WIDTH-1:0] quotient;
      logic                  undefined;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_RED_NUM,
      ST_LOAD_DEN,
      ST_RED_DEN,
      ST_INIT,
      ST_TEST,
      ST_EUCLID,
      ST_UPDATE,
      ST_LOAD_MUL,
      ST_MULT,
      ST_OUTPUT
   } state_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_ACCEPT,
      OP_DIV_STEP,
      OP_LOAD_DEN,
      OP_INIT,
      OP_LOAD_EUCLID,
      OP_UPDATE,
      OP_LOAD_MUL,
      OP_MUL_STEP,
      OP_OUTPUT
   } op_type;

   typedef struct packed {
      op_type op;
   } cmd_type;

   typedef struct packed {
      logic mod_zero;
      logic r1_zero;
      logic r0_one;
      logic out_free;
   } status_type;

endpackage

`default_nettype wire

[hw/rtl/modular_divide.sv]
// Modular division: quotient = dividend * divisor^-1 mod modulus.
// Request channel (req_valid / req_ready / req_data) carries one transaction
// with a dividend and a divisor; response channel (rsp_valid / rsp_ready /
// rsp_data) returns one transaction with the quotient and an undefined flag,
// set with a zero quotient when divisor and modulus are not coprime or when
// the modulus is zero. The modulus is written through csr_wr_en /
// csr_wr_data; the user must write it only while the block is idle, which
// the block itself does not enforce; reset loads 1000000007. One transaction
// is processed at a time. A shared restoring divider gives one quotient bit
// per cycle, and a modular shift-add unit runs beside it. For 32 bits there
// are up to about 46 extended Euclid steps. An undefined result skips the
// final multiply. With a zero modulus the block goes straight from accept
// to the output state. After the result is loaded the block returns to
// idle and takes the next request.
// The result sits in an output register; a new request is taken while it
// waits. If the receiver stalls, the next result holds in the engine until
// the output register is free. Reset clears control state and drops any
// transaction in progress.
`timescale 1ns / 1ps
`default_nettype none

module modular_divide
   import md_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_wr_en,
   input  logic [DATA_WIDTH-1:0] csr_wr_data,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_type               rsp_data
);

   cmd_type    cmd;
   status_type status;

   md_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   md_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_data    (req_data),
      .cmd         (cmd),
      .status      (status),
      .rsp_ready   (rsp_ready),
      .rsp_valid   (rsp_valid),
      .rsp_data    (rsp_data)
   );

endmodule

`default_nettype wire

[hw/rtl/md_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none

module md_ctrl
   import md_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type              state_ff, state_in;
   logic [CNT_WIDTH-1:0]   cnt_ff, cnt_in;
   logic                   cnt_last;

   assign cnt_last = (cnt_ff == CNT_WIDTH'(DATA_WIDTH - 1));

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = status.mod_zero ? ST_OUTPUT : ST_RED_NUM;
            end
         end
         ST_RED_NUM: begin
            if (cnt_last) begin
               state_in = ST_LOAD_DEN;
            end
         end
         ST_LOAD_DEN: state_in = ST_RED_DEN;
         ST_RED_DEN: begin
            if (cnt_last) begin
               state_in = ST_INIT;
            end
         end
         ST_INIT: state_in = ST_TEST;
         ST_TEST: begin
            if (!status.r1_zero) begin
               state_in = ST_EUCLID;
            end else if (status.r0_one) begin
               state_in = ST_LOAD_MUL;
            end else begin
               state_in = ST_OUTPUT;
            end
         end
         ST_EUCLID: begin
            if (cnt_last) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE:   state_in = ST_TEST;
         ST_LOAD_MUL: state_in = ST_MULT;
         ST_MULT: begin
            if (cnt_last) begin
               state_in = ST_OUTPUT;
            end
         end
         ST_OUTPUT: begin
            if (status.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready = 1'b0;
      cmd.op    = OP_NONE;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.op = OP_ACCEPT;
            end
         end
         ST_RED_NUM:  cmd.op = OP_DIV_STEP;
         ST_LOAD_DEN: cmd.op = OP_LOAD_DEN;
         ST_RED_DEN:  cmd.op = OP_DIV_STEP;
         ST_INIT:     cmd.op = OP_INIT;
         ST_TEST: begin
            if (!status.r1_zero) begin
               cmd.op = OP_LOAD_EUCLID;
            end
         end
         ST_EUCLID:   cmd.op = OP_DIV_STEP;
         ST_UPDATE:   cmd.op = OP_UPDATE;
         ST_LOAD_MUL: cmd.op = OP_LOAD_MUL;
         ST_MULT:     cmd.op = OP_MUL_STEP;
         ST_OUTPUT: begin
            if (status.out_free) begin
               cmd.op = OP_OUTPUT;
            end
         end
         default:     cmd.op = OP_NONE;
      endcase
   end

   assign cnt_in = (cmd.op == OP_DIV_STEP || cmd.op == OP_MUL_STEP) ?
                   cnt_ff + CNT_WIDTH'(1) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      cmd.op == OP_OUTPUT |-> status.out_free)
      else $error("result loaded while output register still occupied");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RED_NUM && cnt_last) |=> state_ff == ST_LOAD_DEN)
      else $error("dividend reduction did not end after a full pass");

endmodule

`default_nettype wire

[hw/rtl/md_datapath.sv]
`timescale 1ns / 1ps
`default_nettype none

module md_datapath
   import md_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_wr_en,
   input  logic [DATA_WIDTH-1:0] csr_wr_data,
   input  req_type               req_data,
   input  cmd_type               cmd,
   output status_type            status,
   input  logic                  rsp_ready,
   output logic                  rsp_valid,
   output rsp_type               rsp_data
);

   localparam int unsigned W = DATA_WIDTH;

   logic [W-1:0] modulus_ff;
   logic [W-1:0] num_ff, num_in;
   logic [W-1:0] den_ff, den_in;
   logic [W-1:0] r0_ff, r0_in;
   logic [W-1:0] r1_ff, r1_in;
   logic [W-1:0] t0_ff, t0_in;
   logic [W-1:0] t1_ff, t1_in;
   logic [W-1:0] acc_ff, acc_in;
   logic [W-1:0] dvd_ff, dvd_in;
   logic [W-1:0] dvs_ff, dvs_in;
   logic [W-1:0] rem_ff, rem_in;
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_type      rsp_data_ff, rsp_data_in;

   logic [W:0]   trial;
   logic         q_bit;
   logic [W-1:0] rem_step;
   logic         h_bit;
   logic [W-1:0] h_addend;
   logic [W:0]   dbl;
   logic [W:0]   dbl_red;
   logic [W:0]   h_sum;
   logic [W:0]   h_res;
   logic [W-1:0] t_diff;
   logic [W-1:0] t_next;
   logic         mod_one;
   logic         undef;

   // divider step: restoring, one quotient bit per cycle, MSB first
   assign trial    = {rem_ff, dvd_ff[W-1]};
   assign q_bit    = (trial >= {1'b0, dvs_ff});
   assign rem_step = q_bit ? W'(trial - {1'b0, dvs_ff}) : trial[W-1:0];

   // modular Horner step: acc = 2*acc + bit*addend mod modulus
   assign h_bit    = (cmd.op == OP_MUL_STEP) ? dvd_ff[W-1] : q_bit;
   assign h_addend = h_bit ? ((cmd.op == OP_MUL_STEP) ? t0_ff : t1_ff) : '0;
   assign dbl      = {acc_ff, 1'b0};
   assign dbl_red  = (dbl >= {1'b0, modulus_ff}) ? dbl - {1'b0, modulus_ff} : dbl;
   assign h_sum    = {1'b0, dbl_red[W-1:0]} + {1'b0, h_addend};
   assign h_res    = (h_sum >= {1'b0, modulus_ff}) ? h_sum - {1'b0, modulus_ff} : h_sum;

   // Bezout coefficient update: t0 - q*t1 mod modulus
   assign t_diff = t0_ff - acc_ff;
   assign t_next = (t0_ff >= acc_ff) ? t_diff : t_diff + modulus_ff;

   assign mod_one = (modulus_ff == W'(1));
   assign undef   = status.mod_zero | ~status.r0_one;

   always_comb begin
      num_in       = num_ff;
      den_in       = den_ff;
      r0_in        = r0_ff;
      r1_in        = r1_ff;
      t0_in        = t0_ff;
      t1_in        = t1_ff;
      acc_in       = acc_ff;
      dvd_in       = dvd_ff;
      dvs_in       = dvs_ff;
      rem_in       = rem_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      case (cmd.op)
         OP_ACCEPT: begin
            num_in = req_data.dividend;
            den_in = req_data.divisor;
            dvd_in = req_data.dividend;
            dvs_in = modulus_ff;
            rem_in = '0;
         end
         OP_DIV_STEP: begin
            rem_in = rem_step;
            dvd_in = {dvd_ff[W-2:0], 1'b0};
            acc_in = h_res[W-1:0];
         end
         OP_LOAD_DEN: begin
            num_in = rem_ff;
            dvd_in = den_ff;
            dvs_in = modulus_ff;
            rem_in = '0;
         end
         OP_INIT: begin
            r0_in = modulus_ff;
            r1_in = rem_ff;
            t0_in = '0;
            t1_in = {{(W-1){1'b0}}, ~mod_one};
         end
         OP_LOAD_EUCLID: begin
            dvd_in = r0_ff;
            dvs_in = r1_ff;
            rem_in = '0;
            acc_in = '0;
         end
         OP_UPDATE: begin
            r0_in = r1_ff;
            r1_in = rem_ff;
            t0_in = t1_ff;
            t1_in = t_next;
         end
         OP_LOAD_MUL: begin
            dvd_in = num_ff;
            acc_in = '0;
         end
         OP_MUL_STEP: begin
            dvd_in = {dvd_ff[W-2:0], 1'b0};
            acc_in = h_res[W-1:0];
         end
         OP_OUTPUT: begin
            rsp_valid_in          = 1'b1;
            rsp_data_in.undefined = undef;
            rsp_data_in.quotient  = undef ? '0 : acc_ff;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         modulus_ff   <= MODULUS_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            modulus_ff <= csr_wr_data;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      num_ff      <= num_in;
      den_ff      <= den_in;
      r0_ff       <= r0_in;
      r1_ff       <= r1_in;
      t0_ff       <= t0_in;
      t1_ff       <= t1_in;
      acc_ff      <= acc_in;
      dvd_ff      <= dvd_in;
      dvs_ff      <= dvs_in;
      rem_ff      <= rem_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign status.mod_zero = (modulus_ff == '0);
   assign status.r1_zero  = (r1_ff == '0);
   assign status.r0_one   = (r0_ff == W'(1));
   assign status.out_free = ~rsp_valid_ff | rsp_ready;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assert property (@(posedge clock) disable iff (reset)
      cmd.op == OP_DIV_STEP |-> dvs_ff != '0)
      else $error("division step with zero divisor");

   assert property (@(posedge clock) disable iff (reset)
      cmd.op == OP_DIV_STEP |=> rem_ff < dvs_ff)
      else $error("partial remainder not below divisor");

   assert property (@(posedge clock) disable iff (reset)
      cmd.op == OP_UPDATE |=> (t1_ff < modulus_ff && t0_ff < modulus_ff))
      else $error("Bezout coefficient left the residue range");

endmodule

`default_nettype wire
